/* rtl/ps2md_pkg.sv */
// ----------------------------------------------------------------------------
// ps2md_pkg - shared definitions for the PS/2 mouse packet decoder
// Event codes, register indexes, request kinds, header bits, reset bounds and the event slot types.
// ----------------------------------------------------------------------------
package ps2md_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int ACCUM_BITS_DEF = 32;

   localparam int MAX_EVENTS = 4;

   // event kinds
   localparam logic [1:0] EV_MOVE   = 2'd0;
   localparam logic [1:0] EV_DOWN   = 2'd1;
   localparam logic [1:0] EV_UP     = 2'd2;
   localparam logic [1:0] EV_REPORT = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_GUI_MODE      = 2'd0;
   localparam logic [1:0] CSR_ACCUM_MODE    = 2'd1;
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd3;

   // request kinds
   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_REPORT = 1'b1;

   // header byte bits
   localparam int HDR_SYNC_BIT = 3;
   localparam int HDR_XSIGN    = 4;
   localparam int HDR_YSIGN    = 5;
   localparam int HDR_XOVF     = 6;
   localparam int HDR_YOVF     = 7;

   localparam logic [12:0] WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] HEIGHT_RESET = 13'd768;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] info;
      logic       last;
   } ev_slot_type;

   typedef struct packed {
      logic [2:0]                   count;
      ev_slot_type [MAX_EVENTS-1:0] slot;
   } ev_set_type;

endpackage

/* rtl/ps2_mouse_packet_decoder.sv */
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder - PS/2 three-byte mouse packet decoder
// Assembles mouse packets, tracks pointer or raw sums, emits pointer events.
// ----------------------------------------------------------------------------
// Bytes from the mouse come in on the req_ stream, one transaction per byte;
// a transaction with req_tuser set asks for the raw delta sums instead. A
// packet starts only on a byte with bit 3 set and is three bytes long; a
// packet with an overflow bit set is dropped. Each transaction is decoded in
// the cycle it is taken: the state is updated and its events (none to four)
// land in a four-slot event queue, which feeds the rsp_ output register one
// event per cycle while that register is empty or being taken. A transaction
// that gives no event leaves req_tready high, so such bytes go at one per
// cycle. While the queue holds events req_tready is low: an item with n
// events (one for a report, at most four for a packet with a move and three
// button changes) is taken, then holds req_tready low while its events move
// out, and longer while rsp_tready is low with a result waiting. The next
// byte is taken in the cycle after the last queued event moves to the output
// register, while that result may still wait there. The csr_ port is always
// ready and is meant to be written while no transaction is in flight. Writing
// the accumulate-mode register clears both sums; writing a bound clamps the
// pointer on that axis at once. rsp_tlast marks the final event of a request
// transaction.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder #(
   parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEF,
   parameter int ACCUM_BITS = ps2md_pkg::ACCUM_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] data_byte, [10:8] modifier_keys
   input  logic [0:0]  req_tuser,  // [0] req_type
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pointer_x, pointer_y, button_info[2:0], modifier_state[2:0],
   // delta_x[31:0], delta_y[31:0], zero fill
   output logic [((2*COORD_BITS+70+7)/8)*8-1:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // [1:0] event_kind
   output logic        rsp_tlast,  // last_flag
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   localparam int RSP_W = ((2*COORD_BITS+70+7)/8)*8;
   localparam int CMAX  = (1 << COORD_BITS) - 1;
   localparam int PW    = COORD_BITS + 2;

   // packet assembly states
   localparam logic [1:0] BP_HEADER = 2'd0;
   localparam logic [1:0] BP_XBYTE  = 2'd1;
   localparam logic [1:0] BP_YBYTE  = 2'd2;

   function automatic logic [COORD_BITS-1:0] axis_limit(input logic [12:0] bound);
      int v;
      v = int'(bound) - 1;
      if (v < 0) v = 0;
      if (v > CMAX) v = CMAX;
      return COORD_BITS'(v);
   endfunction

   // configuration
   logic                  gui_ff, gui_in;
   logic                  raw_ff, raw_in;
   logic [COORD_BITS-1:0] lim_x_ff, lim_x_in;
   logic [COORD_BITS-1:0] lim_y_ff, lim_y_in;

   // decoder state
   logic [1:0]            bp_ff, bp_in;
   logic [7:0]            hdr_ff, hdr_in;
   logic [7:0]            xb_ff, xb_in;
   logic [COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [2:0]            mask_ff, mask_in;
   logic [ACCUM_BITS-1:0] sum_x_ff, sum_x_in;
   logic [ACCUM_BITS-1:0] sum_y_ff, sum_y_in;

   logic                  req_fire, csr_fire;
   logic                  req_kind;
   logic [7:0]            data_byte;
   logic [2:0]            mods;
   logic                  q_busy;

   logic signed [8:0]     dx9, dy9;
   logic signed [PW-1:0]  nx, ny;
   logic [COORD_BITS-1:0] cx, cy;
   logic [COORD_BITS-1:0] wlim;

   ps2md_pkg::ev_set_type set;
   logic [2:0]            n;
   logic [31:0]           sh_dx, sh_dy;

   logic [COORD_BITS-1:0] o_px, o_py;
   logic [2:0]            o_info, o_mods;
   logic [31:0]           o_dx, o_dy;

   assign req_tready = !q_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   assign req_kind  = req_tuser[0];
   assign data_byte = req_tdata[7:0];
   assign mods      = req_tdata[10:8];

   // deltas of the packet completed by this byte
   assign dx9 = {hdr_ff[ps2md_pkg::HDR_XSIGN], xb_ff};
   assign dy9 = {hdr_ff[ps2md_pkg::HDR_YSIGN], data_byte};

   // pointer move with clamp; y runs opposite to the mouse
   assign nx = $signed({2'b00, pos_x_ff}) + PW'(dx9);
   assign ny = $signed({2'b00, pos_y_ff}) - PW'(dy9);

   always_comb begin
      if (nx < 0) cx = '0;
      else if (nx > $signed({2'b00, lim_x_ff})) cx = lim_x_ff;
      else cx = nx[COORD_BITS-1:0];
      if (ny < 0) cy = '0;
      else if (ny > $signed({2'b00, lim_y_ff})) cy = lim_y_ff;
      else cy = ny[COORD_BITS-1:0];
   end

   assign wlim = axis_limit(csr_data);

   // decode one transaction
   always_comb begin
      bp_in    = bp_ff;
      hdr_in   = hdr_ff;
      xb_in    = xb_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      mask_in  = mask_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      set      = '0;
      n        = 3'd0;
      sh_dx    = 32'd0;
      sh_dy    = 32'd0;

      if (req_fire) begin
         if (req_kind == ps2md_pkg::REQ_REPORT) begin
            set.count        = 3'd1;
            set.slot[0].kind = ps2md_pkg::EV_REPORT;
            set.slot[0].info = mask_ff;
            set.slot[0].last = 1'b1;
            sh_dx            = 32'($signed(sum_x_ff));
            sh_dy            = 32'($signed(sum_y_ff));
            sum_x_in         = '0;
            sum_y_in         = '0;
         end else begin
            case (bp_ff)
               BP_HEADER: begin
                  if (data_byte[ps2md_pkg::HDR_SYNC_BIT]) begin
                     hdr_in = data_byte;
                     bp_in  = BP_XBYTE;
                  end
               end
               BP_XBYTE: begin
                  xb_in = data_byte;
                  bp_in = BP_YBYTE;
               end
               BP_YBYTE: begin
                  bp_in = BP_HEADER;
                  if (!hdr_ff[ps2md_pkg::HDR_XOVF] && !hdr_ff[ps2md_pkg::HDR_YOVF]) begin
                     mask_in = hdr_ff[2:0];
                     if (raw_ff) begin
                        sum_x_in = sum_x_ff + ACCUM_BITS'(dx9);
                        sum_y_in = sum_y_ff + ACCUM_BITS'(dy9);
                     end else begin
                        pos_x_in = cx;
                        pos_y_in = cy;
                     end
                     if (gui_ff) begin
                        if (dx9 != 9'sd0 || dy9 != 9'sd0) begin
                           set.slot[n[1:0]].kind = ps2md_pkg::EV_MOVE;
                           set.slot[n[1:0]].info = hdr_ff[2:0];
                           n = n + 3'd1;
                        end
                        for (int b = 0; b < 3; b++) begin
                           if (hdr_ff[b] != mask_ff[b]) begin
                              set.slot[n[1:0]].kind = hdr_ff[b] ? ps2md_pkg::EV_DOWN
                                                                : ps2md_pkg::EV_UP;
                              set.slot[n[1:0]].info = 3'(b + 1);
                              n = n + 3'd1;
                           end
                        end
                        if (n != 3'd0) begin
                           set.slot[n[1:0] - 2'd1].last = 1'b1;
                        end
                        set.count = n;
                     end
                  end
               end
               default: begin
                  bp_in = BP_HEADER;
               end
            endcase
         end
      end

      // register writes that touch decoder state; the user keeps them to idle time only, the block does not enforce it
      if (csr_fire) begin
         case (csr_index)
            ps2md_pkg::CSR_ACCUM_MODE: begin
               sum_x_in = '0;
               sum_y_in = '0;
            end
            ps2md_pkg::CSR_SCREEN_WIDTH: begin
               if (pos_x_in > wlim) pos_x_in = wlim;
            end
            ps2md_pkg::CSR_SCREEN_HEIGHT: begin
               if (pos_y_in > wlim) pos_y_in = wlim;
            end
            default: ;
         endcase
      end
   end

   // register writes; idle-time only is the user's rule, the block does not enforce it
   always_comb begin
      gui_in   = gui_ff;
      raw_in   = raw_ff;
      lim_x_in = lim_x_ff;
      lim_y_in = lim_y_ff;
      if (csr_fire) begin
         case (csr_index)
            ps2md_pkg::CSR_GUI_MODE:      gui_in   = csr_data[0];
            ps2md_pkg::CSR_ACCUM_MODE:    raw_in   = csr_data[0];
            ps2md_pkg::CSR_SCREEN_WIDTH:  lim_x_in = wlim;
            ps2md_pkg::CSR_SCREEN_HEIGHT: lim_y_in = wlim;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gui_ff   <= 1'b0;
         raw_ff   <= 1'b0;
         lim_x_ff <= axis_limit(ps2md_pkg::WIDTH_RESET);
         lim_y_ff <= axis_limit(ps2md_pkg::HEIGHT_RESET);
         bp_ff    <= BP_HEADER;
         hdr_ff   <= 8'd0;
         xb_ff    <= 8'd0;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         mask_ff  <= 3'd0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else begin
         gui_ff   <= gui_in;
         raw_ff   <= raw_in;
         lim_x_ff <= lim_x_in;
         lim_y_ff <= lim_y_in;
         bp_ff    <= bp_in;
         hdr_ff   <= hdr_in;
         xb_ff    <= xb_in;
         mask_ff  <= mask_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
      end
   end

   // events of one transaction share position, modifiers and deltas
   ps2md_evq #(
      .COORD_BITS(COORD_BITS)
   ) u_evq (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire && (set.count != 3'd0)),
      .set       (set),
      .sh_pos_x  (pos_x_in),
      .sh_pos_y  (pos_y_in),
      .sh_mods   (mods),
      .sh_dx     (sh_dx),
      .sh_dy     (sh_dy),
      .busy      (q_busy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_info  (o_info),
      .out_last  (rsp_tlast),
      .out_pos_x (o_px),
      .out_pos_y (o_py),
      .out_mods  (o_mods),
      .out_dx    (o_dx),
      .out_dy    (o_dy)
   );

   assign rsp_tdata = RSP_W'({o_dy, o_dx, o_mods, o_info, o_py, o_px});

endmodule

/* rtl/ps2md_evq.sv */
// ----------------------------------------------------------------------------
// ps2md_evq - event queue and result register
// Holds the events of one item and hands them out one per cycle while the result register is empty or being taken.
// ----------------------------------------------------------------------------
module ps2md_evq #(
   parameter int COORD_BITS = ps2md_pkg::COORD_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // load side
   input  logic                      load,
   input  ps2md_pkg::ev_set_type     set,
   input  logic [COORD_BITS-1:0]     sh_pos_x,
   input  logic [COORD_BITS-1:0]     sh_pos_y,
   input  logic [2:0]                sh_mods,
   input  logic [31:0]               sh_dx,
   input  logic [31:0]               sh_dy,
   output logic                      busy,
   // result side
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [1:0]                out_kind,
   output logic [2:0]                out_info,
   output logic                      out_last,
   output logic [COORD_BITS-1:0]     out_pos_x,
   output logic [COORD_BITS-1:0]     out_pos_y,
   output logic [2:0]                out_mods,
   output logic [31:0]               out_dx,
   output logic [31:0]               out_dy
);

   localparam int NS = ps2md_pkg::MAX_EVENTS;

   ps2md_pkg::ev_slot_type [NS-1:0] slot_ff, slot_in;
   logic [2:0] cnt_ff, cnt_in;

   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [2:0]            mods_ff;
   logic [31:0]           dx_ff, dy_ff;

   logic                  ov_ff, ov_in;
   ps2md_pkg::ev_slot_type oslot_ff;
   logic [COORD_BITS-1:0] opx_ff, opy_ff;
   logic [2:0]            omods_ff;
   logic [31:0]           odx_ff, ody_ff;

   logic advance;

   assign advance = (cnt_ff != 3'd0) && (!ov_ff || out_ready);

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         slot_in = set.slot;
         cnt_in  = set.count;
      end else if (advance) begin
         for (int i = 0; i < NS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         slot_in[NS-1] = '0;
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (advance) begin
         ov_in = 1'b1;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         ov_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
      slot_ff <= slot_in;
      if (load) begin
         px_ff   <= sh_pos_x;
         py_ff   <= sh_pos_y;
         mods_ff <= sh_mods;
         dx_ff   <= sh_dx;
         dy_ff   <= sh_dy;
      end
      if (advance) begin
         oslot_ff <= slot_ff[0];
         opx_ff   <= px_ff;
         opy_ff   <= py_ff;
         omods_ff <= mods_ff;
         odx_ff   <= dx_ff;
         ody_ff   <= dy_ff;
      end
   end

   assign busy      = (cnt_ff != 3'd0);
   assign out_valid = ov_ff;
   assign out_kind  = oslot_ff.kind;
   assign out_info  = oslot_ff.info;
   assign out_last  = oslot_ff.last;
   assign out_pos_x = opx_ff;
   assign out_pos_y = opy_ff;
   assign out_mods  = omods_ff;
   assign out_dx    = odx_ff;
   assign out_dy    = ody_ff;

`ifndef NO_ASSERTIONS
   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> cnt_ff == 3'd0)
      else $error("event set loaded over pending events");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> cnt_ff == $past(set.count))
      else $error("queue count does not match loaded set");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 3'd0 |-> slot_ff[cnt_ff[1:0] - 2'd1].last)
      else $error("final queued event not marked last");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> ov_ff)
      else $error("queued event did not reach result register");
`endif

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the PS/2 mouse packet decoder
// Drives mouse bytes and sum reports through the req_ stream, gets each event
// from a decoder model or a pinned plan row, and checks each rsp_ transaction in
// order. A short directed list comes first, then randomized packet traffic
// over several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CB          = ps2md_pkg::COORD_BITS_DEF;
   localparam int COORD_LIM   = (1 << CB) - 1;
   localparam int RSP_W       = ((2*CB+70+7)/8)*8;

   localparam int IDLE_PCT       = 6;     // chance of a stall, per hundred
   localparam int SQUEEZE_CYCLES = 200;   // long receiver hold-off
   localparam int SETTLE_CYCLES  = 4;     // decoder latency margin before a csr write
   localparam int DRAIN_CYCLES   = 20;
   localparam int STALL_LIMIT    = 4000;  // cycles without any transaction
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 22;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [1:0]    kind;
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic [2:0]    info;
      logic [2:0]    mods;
      logic [31:0]   dx;
      logic [31:0]   dy;
      logic          last;
   } mouse_event_type;

   // one line of the directed list: a csr write or a request transaction
   typedef struct {
      bit              is_reg;
      logic [1:0]      reg_idx;
      logic [12:0]     reg_val;
      logic            rtype;
      logic [7:0]      b;
      logic [2:0]      mods;
      int              pin_n;    // -1: predicted, else count of typed-in events (0/1)
      mouse_event_type pin_ev;
   } plan_row_type;

   // ---------------------------------------------------------------- clocking
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- DUT ports
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [15:0]      req_tdata  = '0;   // [7:0] data_byte, [10:8] modifier_keys
   logic [0:0]       req_tuser  = '0;   // [0] req_type
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;         // pointer_x, pointer_y, button_info,
                                        // modifier_state, delta_x, delta_y, fill
   logic [1:0]       rsp_tuser;         // [1:0] event_kind
   logic             rsp_tlast;         // last_flag
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index  = '0;
   logic [12:0]      csr_data   = '0;

   ps2_mouse_packet_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------- decoder model state
   logic          m_gui    = 1'b0;
   logic          m_raw    = 1'b0;
   logic [12:0]   m_width  = ps2md_pkg::WIDTH_RESET;
   logic [12:0]   m_height = ps2md_pkg::HEIGHT_RESET;
   logic [1:0]    m_slot   = '0;    // byte position within the packet
   logic [7:0]    m_hdr    = '0;
   logic [7:0]    m_xbyte  = '0;
   int            m_px     = 0;
   int            m_py     = 0;
   logic [2:0]    m_mask   = '0;
   logic [31:0]   m_sum_x  = '0;
   logic [31:0]   m_sum_y  = '0;

   mouse_event_type fresh_events[$];    // events of the transaction just taken
   mouse_event_type pending_events[$];  // events still owed by the DUT
   plan_row_type    plan[$];

   int            mismatches  = 0;
   int            quiet_cycles = 0;
   int            counted     = 0;    // items not dropped while hunting for a header
   logic          calm        = 1'b0; // no stalls on either side
   logic          squeeze     = 1'b0; // receiver hold-off in progress
   bit            squeeze_arm = 1'b0;

   // clamp limit is bound-1, a zero bound acts as one, never past the coordinate range
   function automatic int clamp_coord(int v, logic [12:0] bound);
      int lim;
      lim = (bound == 13'd0) ? 0 : int'(bound) - 1;
      if (lim > COORD_LIM) lim = COORD_LIM;
      if (v < 0) v = 0;
      if (v > lim) v = lim;
      return v;
   endfunction

   function automatic void apply_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
         ps2md_pkg::CSR_GUI_MODE: m_gui = val[0];
         ps2md_pkg::CSR_ACCUM_MODE: begin
            m_raw   = val[0];
            m_sum_x = '0;
            m_sum_y = '0;
         end
         ps2md_pkg::CSR_SCREEN_WIDTH: begin
            m_width = val;
            m_px    = clamp_coord(m_px, m_width);
         end
         ps2md_pkg::CSR_SCREEN_HEIGHT: begin
            m_height = val;
            m_py     = clamp_coord(m_py, m_height);
         end
         default: ;
      endcase
   endfunction

   function automatic void note_event(logic [1:0] kind, logic [2:0] info, logic [2:0] mods,
                                      logic [31:0] dx, logic [31:0] dy);
      mouse_event_type ev;
      ev.kind = kind;
      ev.px   = m_px[CB-1:0];
      ev.py   = m_py[CB-1:0];
      ev.info = info;
      ev.mods = mods;
      ev.dx   = dx;
      ev.dy   = dy;
      ev.last = 1'b0;
      fresh_events.push_back(ev);
   endfunction

   // Advances the model by one request transaction and leaves its events in
   // fresh_events. Returns 1 when the byte is dropped while hunting for a header.
   function automatic bit decode_item(logic rtype, logic [7:0] b, logic [2:0] mods);
      int              dx;
      int              dy;
      logic [2:0]      prev;
      mouse_event_type tail;
      fresh_events.delete();
      if (rtype == ps2md_pkg::REQ_REPORT) begin
         // report leaves packet assembly alone, clears the sums
         note_event(ps2md_pkg::EV_REPORT, m_mask, mods, m_sum_x, m_sum_y);
         m_sum_x = '0;
         m_sum_y = '0;
      end else if (m_slot == 2'd0) begin
         if (!b[ps2md_pkg::HDR_SYNC_BIT]) return 1'b1;
         m_hdr  = b;
         m_slot = 2'd1;
      end else if (m_slot == 2'd1) begin
         m_xbyte = b;
         m_slot  = 2'd2;
      end else begin
         m_slot = 2'd0;
         // overflow: dropped
         if (m_hdr[ps2md_pkg::HDR_XOVF] || m_hdr[ps2md_pkg::HDR_YOVF]) return 1'b0;
         dx     = int'(m_xbyte) - (m_hdr[ps2md_pkg::HDR_XSIGN] ? 256 : 0);
         dy     = int'(b) - (m_hdr[ps2md_pkg::HDR_YSIGN] ? 256 : 0);
         prev   = m_mask;
         m_mask = m_hdr[2:0];
         if (m_raw) begin
            m_sum_x = m_sum_x + 32'(dx);
            m_sum_y = m_sum_y + 32'(dy);
         end else begin
            // screen rows grow downward, mouse y grows upward
            m_px = clamp_coord(m_px + dx, m_width);
            m_py = clamp_coord(m_py - dy, m_height);
         end
         if (m_gui) begin
            if (dx != 0 || dy != 0) note_event(ps2md_pkg::EV_MOVE, m_mask, mods, '0, '0);
            for (int k = 0; k < 3; k++) begin
               if (m_mask[k] && !prev[k])
                  note_event(ps2md_pkg::EV_DOWN, 3'(k + 1), mods, '0, '0);
               else if (!m_mask[k] && prev[k])
                  note_event(ps2md_pkg::EV_UP, 3'(k + 1), mods, '0, '0);
            end
         end
      end
      if (fresh_events.size() != 0) begin
         tail      = fresh_events.pop_back();
         tail.last = 1'b1;
         fresh_events.push_back(tail);
      end
      return 1'b0;
   endfunction

   // ----------------------------------------------------------- directed list
   function automatic void plan_pinned(logic rtype, logic [7:0] b, logic [2:0] mods,
                                       int pin_n, mouse_event_type pin_ev);
      plan_row_type row;
      row.is_reg  = 1'b0;
      row.reg_idx = '0;
      row.reg_val = '0;
      row.rtype   = rtype;
      row.b       = b;
      row.mods    = mods;
      row.pin_n   = pin_n;
      row.pin_ev  = pin_ev;
      plan.push_back(row);
   endfunction

   function automatic void plan_item(logic rtype, logic [7:0] b, logic [2:0] mods);
      plan_pinned(rtype, b, mods, -1, '0);
   endfunction

   function automatic void plan_reg(logic [1:0] idx, logic [12:0] val);
      plan_row_type row;
      row        = '{default: '0};
      row.is_reg  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      row.pin_n   = -1;
      plan.push_back(row);
   endfunction

   function automatic logic [12:0] pick_bound();
      case ($urandom_range(7))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'h1FFF;
         default: return 13'($urandom_range(4096, 1));
      endcase
   endfunction

   // ----------------------------------------------------------- stream drivers
   // Offers one request transaction and waits for it to be taken. Inputs change
   // only by NBA at a rising edge; ready is sampled before the edge updates it.
   task automatic send_item(logic rtype, logic [7:0] b, logic [2:0] mods, int pin_n,
                            mouse_event_type pin_ev, output bit ignored);
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, mods, b};
      req_tuser  <= rtype;
      do @(posedge clock); while (!req_tready);
      ignored = decode_item(rtype, b, mods);
      if (pin_n < 0) begin
         foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
      end else if (pin_n > 0) begin
         pending_events.push_back(pin_ev);
      end
   endtask

   task automatic offer_random(logic rtype, logic [7:0] b, logic [2:0] mods);
      bit ign;
      send_item(rtype, b, mods, -1, '0, ign);
      if (!ign) counted++;
   endtask

   // csr writes only with the decoder idle: nothing owed, nothing in flight
   task automatic write_reg(logic [1:0] idx, logic [12:0] val);
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, val);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------ receiver side
   always @(posedge clock) begin
      if (squeeze)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // one long hold-off while the sender keeps offering, so the decoder backs up
   initial begin
      wait (squeeze_arm);
      @(posedge clock);
      squeeze <= 1'b1;
      repeat (SQUEEZE_CYCLES) @(posedge clock);
      squeeze <= 1'b0;
   end

   task automatic flag_mismatch(string what, mouse_event_type want, mouse_event_type seen);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
         $display("   exp kind=%0d x=%0d y=%0d info=%0d mods=%0d dx=%0d dy=%0d last=%0d",
                  want.kind, want.px, want.py, want.info, want.mods,
                  $signed(want.dx), $signed(want.dy), want.last);
         $display("   got kind=%0d x=%0d y=%0d info=%0d mods=%0d dx=%0d dy=%0d last=%0d",
                  seen.kind, seen.px, seen.py, seen.info, seen.mods,
                  $signed(seen.dx), $signed(seen.dy), seen.last);
      end
   endtask

   // result checker: each rsp transaction against the oldest owed event
   always @(posedge clock) begin
      mouse_event_type seen;
      mouse_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind = rsp_tuser;
         seen.px   = rsp_tdata[CB-1:0];
         seen.py   = rsp_tdata[2*CB-1:CB];
         seen.info = rsp_tdata[2*CB+2:2*CB];
         seen.mods = rsp_tdata[2*CB+5:2*CB+3];
         seen.dx   = rsp_tdata[2*CB+37:2*CB+6];
         seen.dy   = rsp_tdata[2*CB+69:2*CB+38];
         seen.last = rsp_tlast;
         if (pending_events.size() == 0) begin
            flag_mismatch("event with none expected", '0, seen);
         end else begin
            want = pending_events.pop_front();
            if (seen !== want) flag_mismatch("event mismatch", want, seen);
         end
      end
   end

   // watchdog: too long without any transaction on any port
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------- stimulus
   initial begin
      mouse_event_type rst_report;
      logic [7:0]      hdr;
      bit              ign;
      logic            gui_on;

      // report straight after reset: everything at zero
      rst_report = '{ps2md_pkg::EV_REPORT, 12'd0, 12'd0, 3'd0, 3'd7, 32'd0, 32'd0, 1'b1};
      plan_pinned(ps2md_pkg::REQ_REPORT, 8'hFF, 3'd7, 1, rst_report);
      plan_pinned(ps2md_pkg::REQ_DATA, 8'h00, 3'd0, 0, '0);        // no sync bit: dropped
      plan_reg(ps2md_pkg::CSR_GUI_MODE, 13'd1);
      // all buttons pressed, large positive x, y past the top edge
      plan_item(ps2md_pkg::REQ_DATA, 8'h0F, 3'd1);
      plan_item(ps2md_pkg::REQ_DATA, 8'h7F, 3'd2);
      plan_item(ps2md_pkg::REQ_DATA, 8'h80, 3'd3);
      // both deltas at -256, all buttons released
      plan_item(ps2md_pkg::REQ_DATA, 8'h38, 3'd4);
      plan_item(ps2md_pkg::REQ_DATA, 8'h00, 3'd4);
      plan_item(ps2md_pkg::REQ_DATA, 8'h00, 3'd4);
      // overflow packet: thrown away
      plan_pinned(ps2md_pkg::REQ_DATA, 8'hC8, 3'd7, 0, '0);
      plan_pinned(ps2md_pkg::REQ_DATA, 8'hFF, 3'd7, 0, '0);
      plan_pinned(ps2md_pkg::REQ_DATA, 8'hFF, 3'd7, 0, '0);
      // no motion, no button change: silent
      plan_pinned(ps2md_pkg::REQ_DATA, 8'h08, 3'd0, 0, '0);
      plan_pinned(ps2md_pkg::REQ_DATA, 8'h00, 3'd0, 0, '0);
      plan_pinned(ps2md_pkg::REQ_DATA, 8'h00, 3'd0, 0, '0);
      plan_item(ps2md_pkg::REQ_REPORT, 8'h5A, 3'd6);
      // zero width, height past the coordinate range
      plan_reg(ps2md_pkg::CSR_SCREEN_WIDTH, 13'd0);
      plan_reg(ps2md_pkg::CSR_SCREEN_HEIGHT, 13'h1FFF);
      plan_item(ps2md_pkg::REQ_DATA, 8'h09, 3'd5);
      plan_item(ps2md_pkg::REQ_DATA, 8'hFF, 3'd5);
      plan_item(ps2md_pkg::REQ_DATA, 8'h01, 3'd5);
      plan_item(ps2md_pkg::REQ_DATA, 8'h28, 3'd2);
      plan_item(ps2md_pkg::REQ_DATA, 8'h00, 3'd2);
      plan_item(ps2md_pkg::REQ_DATA, 8'h01, 3'd2);
      // raw and gui together: events at the unmoved position
      plan_reg(ps2md_pkg::CSR_ACCUM_MODE, 13'd1);
      plan_item(ps2md_pkg::REQ_DATA, 8'h1A, 3'd3);
      plan_item(ps2md_pkg::REQ_DATA, 8'h01, 3'd3);
      plan_item(ps2md_pkg::REQ_DATA, 8'hFF, 3'd3);
      plan_item(ps2md_pkg::REQ_REPORT, 8'h00, 3'd1);
      plan_reg(ps2md_pkg::CSR_SCREEN_WIDTH, 13'd4096);
      plan_reg(ps2md_pkg::CSR_SCREEN_HEIGHT, 13'd1);
      plan_reg(ps2md_pkg::CSR_ACCUM_MODE, 13'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_reg)
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         else
            send_item(plan[i].rtype, plan[i].b, plan[i].mods, plan[i].pin_n,
                      plan[i].pin_ev, ign);
      end

      // random phases, each with a fresh register setting
      for (int phase = 0; phase < PHASES; phase++) begin
         gui_on = (phase == 1) || ($urandom_range(9) < 8);
         write_reg(ps2md_pkg::CSR_GUI_MODE, {12'($urandom), gui_on});
         write_reg(ps2md_pkg::CSR_ACCUM_MODE, {12'($urandom), 1'($urandom_range(9) < 3)});
         write_reg(ps2md_pkg::CSR_SCREEN_WIDTH, pick_bound());
         write_reg(ps2md_pkg::CSR_SCREEN_HEIGHT, pick_bound());
         if (phase == 1) squeeze_arm = 1'b1;
         if (phase == 3) calm <= 1'b1;
         if (phase == 4) calm <= 1'b0;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            case ($urandom_range(99)) inside
               [0:7]: offer_random(ps2md_pkg::REQ_REPORT, 8'($urandom), 3'($urandom));
               // stray byte: dropped while hunting, breaks a packet otherwise
               [8:13]: offer_random(ps2md_pkg::REQ_DATA, 8'($urandom) & 8'hF7, 3'($urandom));
               default: begin
                  hdr = 8'($urandom);
                  hdr[ps2md_pkg::HDR_SYNC_BIT] = 1'b1;
                  if ($urandom_range(9) != 0)
                     hdr[ps2md_pkg::HDR_YOVF:ps2md_pkg::HDR_XOVF] = 2'b00;
                  offer_random(ps2md_pkg::REQ_DATA, hdr, 3'($urandom));
                  for (int k = 0; k < 2; k++) begin
                     if ($urandom_range(9) == 0)
                        offer_random(ps2md_pkg::REQ_REPORT, 8'($urandom), 3'($urandom));
                     offer_random(ps2md_pkg::REQ_DATA, 8'($urandom), 3'($urandom));
                  end
               end
            endcase
         end
      end

      // drain: everything owed must arrive, then a margin for strays
      req_tvalid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/ps2md_pkg.sv
rtl/ps2md_evq.sv
rtl/ps2_mouse_packet_decoder.sv
tb/tb_top.sv
